@@ src/i2csm_pkg.sv @@
package i2csm_pkg;

    // Default sizes of the two byte stores and of the frame length limit.
    localparam int RX_DEPTH_DEF = 4096;
    localparam int TX_DEPTH_DEF = 49152;
    localparam int MAX_LEN_DEF  = 256;

    // Widths of the channel payloads.
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;
    localparam int HDR_W     = 32;
    localparam int POS_W     = 9;
    localparam int LEN_W     = 16;
    localparam int SNAP_W    = 16;
    localparam int CMP_W     = 17;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_BUS_WR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUS_RD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOC_SEND = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOC_RECV = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd1;
    localparam logic [BYTE_W-1:0]    FEATURE_RESET     = 8'h10;
    localparam logic [CFG_DAT_W-1:0] MAX_PAYLOAD_RESET = 9'd256;

    // Frame opcodes.
    localparam logic [BYTE_W-1:0] OP_READ      = 8'h01;
    localparam logic [BYTE_W-1:0] OP_WRITE     = 8'h02;
    localparam logic [BYTE_W-1:0] OP_AVAILABLE = 8'h03;
    localparam logic [BYTE_W-1:0] OP_RESET     = 8'h06;

    // Frame position bookkeeping.
    localparam logic [POS_W-1:0] POS_LIMIT = 9'd511;
    localparam logic [POS_W-1:0] HDR_BYTES = 9'd4;
    localparam logic [POS_W-1:0] HDR_LAST  = 9'd3;

    // Armed reply kinds.
    localparam logic [1:0] RPL_NONE  = 2'd0;
    localparam logic [1:0] RPL_READ  = 2'd1;
    localparam logic [1:0] RPL_AVAIL = 2'd2;

    // Where the byte of a pending result comes from.
    localparam logic [1:0] SRC_CALC = 2'd0;
    localparam logic [1:0] SRC_TX   = 2'd1;
    localparam logic [1:0] SRC_RX   = 2'd2;

    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } fifo_ctrl_t;

endpackage

@@ src/i2csm_if.sv @@
interface i2csm_item_if
    import i2csm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, cmd, data_byte, last_byte, input ready);
    modport sink   (input valid, cmd, data_byte, last_byte, output ready);
endinterface

interface i2csm_result_if
    import i2csm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_data;
    logic                out_valid;
    logic [STATUS_W-1:0] status;

    modport source (output valid, out_data, out_valid, status, input ready);
    modport sink   (input valid, out_data, out_valid, status, output ready);
endinterface

interface i2csm_cfg_if
    import i2csm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] addr;
    logic [CFG_DAT_W-1:0] wdata;

    modport source (output valid, addr, wdata, input ready);
    modport sink   (input valid, addr, wdata, output ready);
endinterface

@@ src/i2c_slave_fifo_mailbox_unit.sv @@
// I2C slave mailbox with a receive byte queue and a transmit byte queue.
// req carries one item per byte event: a bus write byte (last_byte marks the
// stop condition), a bus read byte, a local send byte or a local receive.
// rsp returns exactly one result per item, in order: out_data, out_valid and
// status. cfg writes feature_code (index 0) and max_payload (index 1); it is
// always ready. The user must write cfg only while no item is in flight;
// the block does not enforce this. An accepted item updates the pointers and
// issues its queue read at the acceptance edge; the result is held in the
// pending stage, then moves into the rsp register once that register is free
// (empty or being taken), which raises rsp.valid.
// Throughput is one item per cycle while rsp is taken, set by the single
// read-or-write access each queue memory makes per cycle.
// If rsp stalls, the output register and the pending stage hold one result
// each, then req.ready drops until rsp.ready returns.
// Reset empties both queues, clears the frame and any armed reply, and loads
// the register defaults; memory contents are not cleared, the fill counts
// guard every read, so no clearing pass follows reset.
module i2c_slave_fifo_mailbox_unit
    import i2csm_pkg::*;
#(
    parameter int RX_DEPTH = RX_DEPTH_DEF,
    parameter int TX_DEPTH = TX_DEPTH_DEF,
    parameter int MAX_LEN  = MAX_LEN_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    i2csm_item_if.sink     req,
    i2csm_result_if.source rsp,
    i2csm_cfg_if.sink      cfg
);

    localparam int RX_FILL_W = $clog2(RX_DEPTH + 1);
    localparam int TX_FILL_W = $clog2(TX_DEPTH + 1);
    localparam int LEFT_W    = (MAX_LEN < 3) ? 2 : $clog2(MAX_LEN + 1);

    function automatic logic hdr_ok(input logic [HDR_W-1:0] h,
                                    input logic [BYTE_W-1:0] feat,
                                    input logic [CFG_DAT_W-1:0] maxp);
        return (h[31:24] == feat) && (h[15:0] <= LEN_W'(maxp))
            && (CMP_W'(h[15:0]) <= CMP_W'(MAX_LEN));
    endfunction

    // Configuration registers.
    logic [BYTE_W-1:0]    feature_reg;
    logic [CFG_DAT_W-1:0] max_payload_reg;

    // Frame and reply state.
    logic [HDR_W-1:0]  frame_header_reg, frame_header_next;
    logic [POS_W-1:0]  frame_pos_reg, frame_pos_next;
    logic [1:0]        reply_mode_reg, reply_mode_next;
    logic [LEFT_W-1:0] reply_left_reg, reply_left_next;
    logic [SNAP_W-1:0] snapshot_reg, snapshot_next;

    // Pending stage and output register.
    logic                pend_vld_reg, pend_vld_next;
    logic [1:0]          pend_src_reg, pend_src_next;
    logic [BYTE_W-1:0]   pend_data_reg, pend_data_next;
    logic                pend_ovalid_reg, pend_ovalid_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                out_vld_reg, out_vld_next;
    logic [BYTE_W-1:0]   out_data_reg, out_data_next;
    logic                out_ovalid_reg, out_ovalid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    fifo_ctrl_t           rx_ctrl, tx_ctrl;
    logic [RX_FILL_W-1:0] rx_fill;
    logic [TX_FILL_W-1:0] tx_fill;
    logic                 rx_full, tx_full;
    logic [BYTE_W-1:0]    rx_rd_data, tx_rd_data;

    logic              accept, out_free, move;
    logic              pos_in_hdr, acc_cur, acc_reg;
    logic [HDR_W-1:0]  hdr_new, hdr_cur;
    logic [CMP_W-1:0]  read_len, tx_avail, read_n;

    i2csm_fifo #(.DEPTH(RX_DEPTH)) u_rx_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rx_ctrl),
        .push_data (req.data_byte),
        .fill      (rx_fill),
        .full      (rx_full),
        .rd_data   (rx_rd_data)
    );

    i2csm_fifo #(.DEPTH(TX_DEPTH)) u_tx_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tx_ctrl),
        .push_data (req.data_byte),
        .fill      (tx_fill),
        .full      (tx_full),
        .rd_data   (tx_rd_data)
    );

    assign out_free  = !out_vld_reg || rsp.ready;
    assign move      = pend_vld_reg && out_free;
    assign req.ready = !pend_vld_reg || out_free;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // During the header bytes the byte is shifted in; the acceptance check of
    // the byte that completes the header sees the shifted value.
    assign pos_in_hdr = (frame_pos_reg < HDR_BYTES);
    assign hdr_new    = {frame_header_reg[HDR_W-9:0], req.data_byte};
    assign hdr_cur    = pos_in_hdr ? hdr_new : frame_header_reg;
    assign acc_cur    = hdr_ok(hdr_cur, feature_reg, max_payload_reg);
    assign acc_reg    = hdr_ok(frame_header_reg, feature_reg, max_payload_reg);
    assign read_len   = CMP_W'(hdr_cur[15:0]);
    assign tx_avail   = CMP_W'(tx_fill);
    assign read_n     = (read_len < tx_avail) ? read_len : tx_avail;

    always_comb
    begin
        frame_header_next = frame_header_reg;
        frame_pos_next    = frame_pos_reg;
        reply_mode_next   = reply_mode_reg;
        reply_left_next   = reply_left_reg;
        snapshot_next     = snapshot_reg;
        rx_ctrl           = '0;
        tx_ctrl           = '0;
        pend_src_next     = pend_src_reg;
        pend_data_next    = pend_data_reg;
        pend_ovalid_next  = pend_ovalid_reg;
        pend_status_next  = pend_status_reg;

        if (accept)
        begin
            pend_src_next    = SRC_CALC;
            pend_data_next   = '0;
            pend_ovalid_next = 1'b0;
            pend_status_next = ST_OK;

            unique case (req.cmd)
                CMD_BUS_WR:
                begin
                    reply_mode_next = RPL_NONE;
                    reply_left_next = '0;
                    if (pos_in_hdr)
                    begin
                        frame_header_next = hdr_new;
                        if (frame_pos_reg == HDR_LAST && !acc_cur)
                        begin
                            pend_status_next = ST_REJECT;
                        end
                    end
                    else if (!acc_reg)
                    begin
                        pend_status_next = ST_REJECT;
                    end
                    else if (frame_header_reg[23:16] == OP_WRITE
                             && LEN_W'(frame_pos_reg - HDR_BYTES) < frame_header_reg[15:0])
                    begin
                        if (rx_full)
                        begin
                            pend_status_next = ST_FULL;
                        end
                        else
                        begin
                            rx_ctrl.push = 1'b1;
                        end
                    end

                    if (frame_pos_reg != POS_LIMIT)
                    begin
                        frame_pos_next = frame_pos_reg + 1'b1;
                    end

                    // Stop condition: a frame cut short inside its header is
                    // rejected, an accepted one is decoded.
                    if (req.last_byte)
                    begin
                        if (frame_pos_reg < HDR_LAST)
                        begin
                            pend_status_next = ST_REJECT;
                        end
                        else if (acc_cur)
                        begin
                            if (hdr_cur[23:16] == OP_READ)
                            begin
                                reply_mode_next = (read_n != '0) ? RPL_READ : RPL_NONE;
                                reply_left_next = LEFT_W'(read_n);
                            end
                            else if (hdr_cur[23:16] == OP_AVAILABLE)
                            begin
                                snapshot_next   = SNAP_W'(tx_fill);
                                reply_mode_next = RPL_AVAIL;
                                reply_left_next = LEFT_W'(2);
                            end
                            else if (hdr_cur[23:16] == OP_RESET)
                            begin
                                rx_ctrl.clear = 1'b1;
                                tx_ctrl.clear = 1'b1;
                            end
                        end
                        frame_pos_next    = '0;
                        frame_header_next = '0;
                    end
                end

                CMD_BUS_RD:
                begin
                    if (reply_mode_reg == RPL_READ && reply_left_reg != '0
                        && tx_fill != '0)
                    begin
                        tx_ctrl.pop      = 1'b1;
                        pend_src_next    = SRC_TX;
                        pend_ovalid_next = 1'b1;
                        reply_left_next  = reply_left_reg - 1'b1;
                    end
                    else if (reply_mode_reg == RPL_AVAIL && reply_left_reg != '0)
                    begin
                        pend_data_next   = (reply_left_reg == LEFT_W'(2))
                                           ? snapshot_reg[15:8] : snapshot_reg[7:0];
                        pend_ovalid_next = 1'b1;
                        reply_left_next  = reply_left_reg - 1'b1;
                    end
                    else
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                    if (reply_left_next == '0)
                    begin
                        reply_mode_next = RPL_NONE;
                    end
                end

                CMD_LOC_SEND:
                begin
                    if (tx_full)
                    begin
                        pend_status_next = ST_FULL;
                    end
                    else
                    begin
                        tx_ctrl.push = 1'b1;
                    end
                end

                CMD_LOC_RECV:
                begin
                    if (rx_fill != '0)
                    begin
                        rx_ctrl.pop      = 1'b1;
                        pend_src_next    = SRC_RX;
                        pend_ovalid_next = 1'b1;
                    end
                    else
                    begin
                        pend_status_next = ST_EMPTY;
                    end
                end
            endcase
        end
    end

    // Queue bytes are picked from the memory read registers as the pending
    // result moves into the output register.
    always_comb
    begin
        pend_vld_next   = accept ? 1'b1 : (move ? 1'b0 : pend_vld_reg);
        out_vld_next    = move ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_reg);
        out_data_next   = out_data_reg;
        out_ovalid_next = out_ovalid_reg;
        out_status_next = out_status_reg;
        if (move)
        begin
            unique case (pend_src_reg)
                SRC_TX:  out_data_next = tx_rd_data;
                SRC_RX:  out_data_next = rx_rd_data;
                default: out_data_next = pend_data_reg;
            endcase
            out_ovalid_next = pend_ovalid_reg;
            out_status_next = pend_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_reg      <= FEATURE_RESET;
            max_payload_reg  <= MAX_PAYLOAD_RESET;
            frame_header_reg <= '0;
            frame_pos_reg    <= '0;
            reply_mode_reg   <= RPL_NONE;
            reply_left_reg   <= '0;
            snapshot_reg     <= '0;
            pend_vld_reg     <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.addr)
                    CFG_FEATURE:     feature_reg     <= cfg.wdata[BYTE_W-1:0];
                    CFG_MAX_PAYLOAD: max_payload_reg <= cfg.wdata;
                endcase
            end
            frame_header_reg <= frame_header_next;
            frame_pos_reg    <= frame_pos_next;
            reply_mode_reg   <= reply_mode_next;
            reply_left_reg   <= reply_left_next;
            snapshot_reg     <= snapshot_next;
            pend_vld_reg     <= pend_vld_next;
            out_vld_reg      <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_src_reg    <= pend_src_next;
        pend_data_reg   <= pend_data_next;
        pend_ovalid_reg <= pend_ovalid_next;
        pend_status_reg <= pend_status_next;
        out_data_reg    <= out_data_next;
        out_ovalid_reg  <= out_ovalid_next;
        out_status_reg  <= out_status_next;
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.out_data  = out_data_reg;
    assign rsp.out_valid = out_ovalid_reg;
    assign rsp.status    = out_status_reg;

endmodule

@@ src/i2csm_fifo.sv @@
module i2csm_fifo
    import i2csm_pkg::*;
#(
    parameter int DEPTH = RX_DEPTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  fifo_ctrl_t                       ctrl,
    input  logic [BYTE_W-1:0]                push_data,
    output logic [$clog2(DEPTH + 1)-1:0]     fill,
    output logic                             full,
    output logic [BYTE_W-1:0]                rd_data
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [BYTE_W-1:0] mem [DEPTH];

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [BYTE_W-1:0] rd_data_reg;

    // The caller pushes only when not full and pops only when not empty.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
        end
        else if (ctrl.push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
        begin
            mem[tail_reg] <= push_data;
        end
        if (ctrl.pop)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign fill    = fill_reg;
    assign full    = (fill_reg == FILL_W'(DEPTH));
    assign rd_data = rd_data_reg;

endmodule
